// ----- rtl/rlpbe_pkg.sv -----
// shared types, codes and the brightness factor table of the bit encoder
package rlpbe_pkg;

  typedef logic [7:0]  chan_t;
  typedef logic [16:0] factor_t;
  typedef logic [6:0]  duty_t;
  typedef logic [5:0]  step_t;

  localparam duty_t DUTY_ONE  = 7'd67;
  localparam duty_t DUTY_ZERO = 7'd33;
  localparam duty_t DUTY_GAP  = 7'd0;
  localparam step_t MAX_STEP  = 6'd45;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_SEND  = 2'd1;
  localparam logic [1:0] FUNC_GAP   = 2'd2;

  localparam logic [0:0] REG_BRIGHT = 1'b0;

  localparam int BITS_PER_LED = 24;

  // round(tan(step deg) * 65536), unsigned q1.16
  function automatic factor_t tan_q16(input step_t step);
    factor_t f;
    begin
      case (step)
        6'd0:    f = 17'd0;
        6'd1:    f = 17'd1144;
        6'd2:    f = 17'd2289;
        6'd3:    f = 17'd3435;
        6'd4:    f = 17'd4583;
        6'd5:    f = 17'd5734;
        6'd6:    f = 17'd6888;
        6'd7:    f = 17'd8047;
        6'd8:    f = 17'd9210;
        6'd9:    f = 17'd10380;
        6'd10:   f = 17'd11556;
        6'd11:   f = 17'd12739;
        6'd12:   f = 17'd13930;
        6'd13:   f = 17'd15130;
        6'd14:   f = 17'd16340;
        6'd15:   f = 17'd17560;
        6'd16:   f = 17'd18792;
        6'd17:   f = 17'd20036;
        6'd18:   f = 17'd21294;
        6'd19:   f = 17'd22566;
        6'd20:   f = 17'd23853;
        6'd21:   f = 17'd25157;
        6'd22:   f = 17'd26478;
        6'd23:   f = 17'd27818;
        6'd24:   f = 17'd29179;
        6'd25:   f = 17'd30560;
        6'd26:   f = 17'd31964;
        6'd27:   f = 17'd33392;
        6'd28:   f = 17'd34846;
        6'd29:   f = 17'd36327;
        6'd30:   f = 17'd37837;
        6'd31:   f = 17'd39378;
        6'd32:   f = 17'd40951;
        6'd33:   f = 17'd42560;
        6'd34:   f = 17'd44205;
        6'd35:   f = 17'd45889;
        6'd36:   f = 17'd47615;
        6'd37:   f = 17'd49385;
        6'd38:   f = 17'd51202;
        6'd39:   f = 17'd53070;
        6'd40:   f = 17'd54991;
        6'd41:   f = 17'd56970;
        6'd42:   f = 17'd59009;
        6'd43:   f = 17'd61113;
        6'd44:   f = 17'd63287;
        default: f = 17'd65536;
      endcase
      return f;
    end
  endfunction

endpackage

// ----- rtl/rlpbe_ram.sv -----
// generic single write port ram with registered read
module rlpbe_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 12
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/rlpbe_scale.sv -----
// shared channel scaler: 8 x 17 multiply, keep bits above the q16 point, registered
module rlpbe_scale
  import rlpbe_pkg::*;
(
  input  logic    clk,
  input  chan_t   chan,
  input  factor_t factor,
  output chan_t   scaled
);

  logic [24:0] prod;
  chan_t       scaled_r;

  assign prod = {17'd0, chan} * {8'd0, factor};

  // factor never exceeds 1.0, so the result fits in eight bits
  always_ff @(posedge clk) begin
    scaled_r <= prod[23:16];
  end

  assign scaled = scaled_r;

endmodule

// ----- rtl/rgb_led_pwm_bit_encoder_top.sv -----
// top level: colour table, scaling sequencer and duty code stream of the led bit encoder
// a colour write gives no word and does not block the input; in_tready stays high
// a send gives its first duty word after the table read and three passes through the
// one shared multiplier, then 24 words at one per cycle when not stalled
// a reset gap gives RESET_SLOTS zero words starting the cycle after acceptance
// a send blocks the input to its last word; rst_n clears the valid bits, brightness to 45
module rgb_led_pwm_bit_encoder_top
  import rlpbe_pkg::*;
#(
  parameter int LED_COUNT   = 12,
  parameter int RESET_SLOTS = 50
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream: func[1:0], led_index[5:2], red[13:6], green[21:14], blue[29:22], zero pad
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  // result stream: duty[6:0], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,
  output logic        out_tlast,
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // only sixteen entries can be addressed by a 4 bit index
  localparam int TBL_DEPTH = (LED_COUNT < 16) ? LED_COUNT : 16;
  localparam int AW        = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
  localparam int CNT_MAX   = (RESET_SLOTS > BITS_PER_LED) ? RESET_SLOTS : BITS_PER_LED;
  localparam int CNT_W     = $clog2(CNT_MAX);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_SEND = 3'd3;
  localparam logic [2:0] ST_GAP  = 3'd4;

  // input word fields
  logic [1:0] in_func;
  logic [3:0] in_idx;
  chan_t      in_red, in_green, in_blue;

  assign in_func  = in_tdata[1:0];
  assign in_idx   = in_tdata[5:2];
  assign in_red   = in_tdata[13:6];
  assign in_green = in_tdata[21:14];
  assign in_blue  = in_tdata[29:22];

  logic [2:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [23:0]          colour_r, colour_nxt;
  logic [23:0]          word_r, word_nxt;
  logic                 hit_r, hit_nxt;
  logic [TBL_DEPTH-1:0] vld_r, vld_nxt;
  step_t                bright_r, bright_nxt;

  logic       in_acc, out_acc, cfg_wr, idx_ok;
  logic [AW-1:0] addr;
  logic       ram_we, ram_re;
  logic [23:0] ram_rdata;
  chan_t      mul_in, mul_out;
  logic       last_beat;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;
  assign idx_ok    = ({1'b0, in_idx} < 5'(TBL_DEPTH));
  assign addr      = in_idx[AW-1:0];

  assign ram_we = in_acc && (in_func == FUNC_WRITE) && idx_ok;
  assign ram_re = in_acc && (in_func == FUNC_SEND);

  rlpbe_ram #(
    .WIDTH (24),
    .DEPTH (TBL_DEPTH)
  ) u_tbl (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata ({in_red, in_green, in_blue}),
    .re    (ram_re),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  // channel order through the multiplier: green, red, blue
  always_comb begin
    case (cnt_r[1:0])
      2'd0:    mul_in = colour_r[15:8];
      2'd1:    mul_in = colour_r[23:16];
      default: mul_in = colour_r[7:0];
    endcase
  end

  rlpbe_scale u_scale (
    .clk    (clk),
    .chan   (mul_in),
    .factor (tan_q16(bright_r)),
    .scaled (mul_out)
  );

  // configuration: brightness saturates at the top step
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr == {REG_BRIGHT, 2'b00});
  assign bright_nxt = cfg_wr ? ((cfg_pwdata[5:0] > MAX_STEP) ? MAX_STEP : cfg_pwdata[5:0])
                             : bright_r;
  assign cfg_prdata = (cfg_paddr == {REG_BRIGHT, 2'b00}) ? {26'd0, bright_r} : 32'd0;

  assign last_beat = (state_r == ST_SEND) ? (cnt_r == CNT_W'(BITS_PER_LED - 1))
                                          : (cnt_r == CNT_W'(RESET_SLOTS - 1));

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    colour_nxt = colour_r;
    word_nxt   = word_r;
    hit_nxt    = hit_r;
    vld_nxt    = vld_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_func)
            FUNC_WRITE: begin
              if (idx_ok) begin
                vld_nxt[addr] = 1'b1;
              end
            end
            FUNC_SEND: begin
              // unwritten or out of range entries send black
              hit_nxt   = idx_ok && vld_r[addr];
              state_nxt = ST_READ;
            end
            FUNC_GAP: begin
              cnt_nxt   = '0;
              state_nxt = ST_GAP;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        colour_nxt = hit_r ? ram_rdata : 24'd0;
        cnt_nxt    = '0;
        state_nxt  = ST_MUL;
      end
      ST_MUL: begin
        // product of the previous channel lands in the cycle after issue
        if (cnt_r != '0) begin
          word_nxt = {word_r[15:0], mul_out};
        end
        if (cnt_r == CNT_W'(3)) begin
          cnt_nxt   = '0;
          state_nxt = ST_SEND;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_SEND: begin
        if (out_acc) begin
          word_nxt = {word_r[22:0], 1'b0};
          cnt_nxt  = cnt_r + CNT_W'(1);
          if (last_beat) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_GAP: begin
        if (out_acc) begin
          cnt_nxt = cnt_r + CNT_W'(1);
          if (last_beat) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      vld_r    <= '0;
      bright_r <= MAX_STEP;
      hit_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      vld_r    <= vld_nxt;
      bright_r <= bright_nxt;
      hit_r    <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    colour_r <= colour_nxt;
    word_r   <= word_nxt;
  end

  // output word straight from the state and the shift register
  assign out_tvalid = (state_r == ST_SEND) || (state_r == ST_GAP);
  assign out_tdata  = (state_r == ST_SEND) ? {1'b0, (word_r[23] ? DUTY_ONE : DUTY_ZERO)}
                                           : {1'b0, DUTY_GAP};
  assign out_tlast  = out_tvalid && last_beat;

endmodule

// ----- test/rgb_led_pwm_bit_encoder_checker.sv -----
// checker for the led bit encoder: watches both streams and the register port, predicts, compares
`timescale 1ns / 100ps

module rgb_led_pwm_bit_encoder_checker
  import rlpbe_pkg::*;
#(
  parameter int LED_COUNT   = 12,
  parameter int RESET_SLOTS = 50
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // func[1:0], led_index[5:2], red[13:6], green[21:14], blue[29:22]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // duty[6:0], zero pad
  input  logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic [31:0] cfg_prdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          pending
);

  localparam logic [2:0] BRIGHT_ADDR = {REG_BRIGHT, 2'b00};

  typedef struct packed {
    duty_t duty;
    logic  last;
  } slot_t;

  // tan(step deg) in unsigned q1.16
  localparam int unsigned FACTOR_LUT [46] = '{
    0, 1144, 2289, 3435, 4583, 5734, 6888, 8047, 9210, 10380,
    11556, 12739, 13930, 15130, 16340, 17560, 18792, 20036, 21294,
    22566, 23853, 25157, 26478, 27818, 29179, 30560, 31964, 33392,
    34846, 36327, 37837, 39378, 40951, 42560, 44205, 45889, 47615,
    49385, 51202, 53070, 54991, 56970, 59009, 61113, 63287, 65536
  };

  chan_t  led_red [LED_COUNT];
  chan_t  led_grn [LED_COUNT];
  chan_t  led_blu [LED_COUNT];
  step_t  level;
  slot_t  duty_due_q [$];
  int     errs;

  function automatic chan_t scale_chan(input chan_t ch, input step_t st);
    logic [24:0] prod;
    begin
      prod = ch * factor_t'(FACTOR_LUT[st]);
      return prod[23:16];
    end
  endfunction

  always @(posedge clk) begin : watch
    logic [1:0]  func;
    logic [3:0]  idx;
    logic [23:0] grb;
    slot_t       got;
    slot_t       want;
    if (!rst_n) begin
      for (int i = 0; i < LED_COUNT; i++) begin
        led_red[i] = '0;
        led_grn[i] = '0;
        led_blu[i] = '0;
      end
      level = MAX_STEP;
      duty_due_q.delete();
      errs = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.duty = out_tdata[6:0];
        got.last = out_tlast;
        if (duty_due_q.size() == 0) begin
          if (errs < 10)
            $display("%0t: unexpected word tdata %0d last %0b", $realtime, out_tdata, out_tlast);
          errs++;
        end else begin
          want = duty_due_q.pop_front();
          if (out_tdata[7] !== 1'b0 || got !== want) begin
            if (errs < 10)
              $display("%0t: duty mismatch, expected %0d last %0b, got tdata %0d last %0b",
                       $realtime, want.duty, want.last, out_tdata, out_tlast);
            errs++;
          end
        end
      end

      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == BRIGHT_ADDR) begin
        if (cfg_pwrite) begin
          level = (cfg_pwdata[5:0] > MAX_STEP) ? MAX_STEP : cfg_pwdata[5:0];
        end else if (cfg_prdata !== {26'd0, level}) begin
          if (errs < 10)
            $display("%0t: brightness read, expected %0d, got %0d", $realtime, level, cfg_prdata);
          errs++;
        end
      end

      if (in_tvalid && in_tready) begin
        func = in_tdata[1:0];
        idx  = in_tdata[5:2];
        case (func)
          FUNC_WRITE: begin
            if (idx < LED_COUNT) begin
              led_red[idx] = in_tdata[13:6];
              led_grn[idx] = in_tdata[21:14];
              led_blu[idx] = in_tdata[29:22];
            end
          end
          FUNC_SEND: begin
            grb = '0;
            if (idx < LED_COUNT)
              grb = {scale_chan(led_grn[idx], level), scale_chan(led_red[idx], level),
                     scale_chan(led_blu[idx], level)};
            for (int k = 0; k < BITS_PER_LED; k++) begin
              want.duty = grb[BITS_PER_LED-1-k] ? DUTY_ONE : DUTY_ZERO;
              want.last = (k == BITS_PER_LED - 1);
              duty_due_q.push_back(want);
            end
          end
          FUNC_GAP: begin
            for (int k = 0; k < RESET_SLOTS; k++) begin
              want.duty = DUTY_GAP;
              want.last = (k == RESET_SLOTS - 1);
              duty_due_q.push_back(want);
            end
          end
          default: ;
        endcase
      end
    end
    fail_count <= errs;
    pending    <= duty_due_q.size();
  end

endmodule

// ----- test/tb_top.sv -----
// testbench top of the led bit encoder: clock, reset, stimulus, idling and the verdict
`timescale 1ns / 100ps

module tb_top;
  import rlpbe_pkg::*;

  localparam int LED_COUNT   = 12;
  localparam int RESET_SLOTS = 50;

  // func code that the block must ignore
  localparam logic [1:0] FUNC_SPARE  = 2'd3;
  localparam logic [2:0] BRIGHT_ADDR = {REG_BRIGHT, 2'b00};

  // margin after the checker queue drains, so this covers any item still in flight
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 36;
  // room for the slowest run: gaps of 50 words behind a receiver stalling often
  localparam int CYCLE_LIMIT   = 600000;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;     // func[1:0], led_index[5:2], red[13:6], green[21:14], blue[29:22]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;    // duty[6:0], zero pad
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int  fail_count;
  int  pending;
  // idling chances in percent; the receiver's ones are read by its own process
  int  send_pct    = 0;
  int  recv_pct    = 0;
  bit  press_armed = 1'b0;
  bit  hold_done   = 1'b0;
  int  hold_left   = 0;

  rgb_led_pwm_bit_encoder_top #(
    .LED_COUNT  (LED_COUNT),
    .RESET_SLOTS(RESET_SLOTS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  rgb_led_pwm_bit_encoder_checker #(
    .LED_COUNT  (LED_COUNT),
    .RESET_SLOTS(RESET_SLOTS)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_top failed");
    $finish;
  end

  // receiver: random stalls per phase, plus one long hold-off so the block backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (press_armed && !hold_done) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_done  <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_pct);
    end
  end

  function automatic int idle_pct(input idle_mode_t mode, input bit recv_side);
    case (mode)
      IDLE_SEND: return recv_side ? 0 : 56;
      IDLE_RECV: return recv_side ? 56 : 0;
      IDLE_BOTH: return 18;
      default:   return 0;
    endcase
  endfunction

  function automatic chan_t rand_chan();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return 8'h00;
    if (pick < 20) return 8'hFF;
    return chan_t'($urandom_range(255));
  endfunction

  // offer one word; tvalid stays high from one word to the next unless the sender idles
  task automatic push_item(input logic [1:0] func, input logic [3:0] idx,
                           input chan_t r, input chan_t g, input chan_t b);
    while ($urandom_range(99) < send_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, b, g, r, idx, func};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic rand_item();
    int         pick;
    logic [1:0] func;
    logic [3:0] idx;
    pick = $urandom_range(99);
    if (pick < 42)      func = FUNC_WRITE;
    else if (pick < 84) func = FUNC_SEND;
    else if (pick < 92) func = FUNC_GAP;
    else                func = FUNC_SPARE;
    // mostly entries in range, now and then past the end of the table
    if ($urandom_range(99) < 88) idx = 4'($urandom_range(LED_COUNT - 1));
    else                         idx = 4'($urandom_range(15, LED_COUNT));
    push_item(func, idx, rand_chan(), rand_chan(), rand_chan());
  endtask

  // brightness write only once the block is idle, then read it back
  task automatic write_bright(input logic [31:0] value);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= BRIGHT_ADDR;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic run_phase(input logic [31:0] value, input idle_mode_t mode, input bit press);
    write_bright(value);
    send_pct    =  idle_pct(mode, 1'b0);
    recv_pct    <= idle_pct(mode, 1'b1);
    press_armed <= press;
    repeat (PHASE_ITEMS) rand_item();
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the reset brightness (full scale)
    push_item(FUNC_WRITE, 4'd0, 8'hFF, 8'hFF, 8'hFF);
    push_item(FUNC_SEND, 4'd0, 8'h00, 8'h00, 8'h00);          // all one bits
    push_item(FUNC_WRITE, 4'd11, 8'h00, 8'h00, 8'h00);
    push_item(FUNC_SEND, 4'd11, 8'hFF, 8'hFF, 8'hFF);         // all zero bits, colour ignored
    push_item(FUNC_WRITE, 4'd5, 8'hAA, 8'h55, 8'h0F);
    push_item(FUNC_SEND, 4'd5, 8'h00, 8'h00, 8'h00);          // green, red, blue order
    // index past the table: write dropped, send gives black
    push_item(FUNC_WRITE, 4'd15, 8'hFF, 8'hFF, 8'hFF);
    push_item(FUNC_SEND, 4'd15, 8'h00, 8'h00, 8'h00);
    push_item(FUNC_WRITE, 4'd12, 8'hFF, 8'hFF, 8'hFF);
    push_item(FUNC_SEND, 4'd12, 8'h00, 8'h00, 8'h00);
    push_item(FUNC_GAP, 4'd0, 8'h00, 8'h00, 8'h00);           // latch gap of zero duties
    push_item(FUNC_SPARE, 4'd7, 8'hFF, 8'h00, 8'hFF);         // unused code, no word
    push_item(FUNC_WRITE, 4'd3, 8'h80, 8'h01, 8'hFE);
    push_item(FUNC_SEND, 4'd3, 8'h00, 8'h00, 8'h00);
    push_item(FUNC_SEND, 4'd1, 8'h00, 8'h00, 8'h00);          // never written, still black
    push_item(FUNC_WRITE, 4'd11, 8'h7F, 8'hC3, 8'h3C);
    push_item(FUNC_SEND, 4'd11, 8'h00, 8'h00, 8'h00);
    push_item(FUNC_GAP, 4'd15, 8'hFF, 8'hFF, 8'hFF);          // gap ignores the other fields
    push_item(FUNC_SEND, 4'd0, 8'h00, 8'h00, 8'h00);

    // random part, one brightness per phase, extremes and saturation among them
    run_phase(32'd0, IDLE_NONE, 1'b0);                        // zero factor, all black
    run_phase(32'd63, IDLE_SEND, 1'b0);                       // saturates to full scale
    run_phase(32'd45, IDLE_RECV, 1'b1);                       // long hold-off in this one
    run_phase(32'd1, IDLE_BOTH, 1'b0);
    run_phase({26'($urandom_range(32'h03FF_FFFF)), 6'($urandom_range(63))}, IDLE_NONE, 1'b0);
    run_phase(32'd44, IDLE_SEND, 1'b0);
    run_phase(32'hFFFF_FFEE, IDLE_BOTH, 1'b0);                // low bits 46, saturates

    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule

// ----- rgb_led_pwm_bit_encoder_top.f -----
rtl/rlpbe_pkg.sv
rtl/rlpbe_ram.sv
rtl/rlpbe_scale.sv
rtl/rgb_led_pwm_bit_encoder_top.sv
test/rgb_led_pwm_bit_encoder_checker.sv
test/tb_top.sv
